// ===== hdl/lsmr_pkg.sv =====
// Shared types, codes and helper functions for the limit switch motor ramp controller.
`timescale 1ns / 1ps

package lsmr_pkg;

    localparam int DUTY_BITS    = 11;
    localparam int ELAPSED_BITS = 12;
    localparam int HOLD_BITS    = 10;
    localparam int STEP_BITS    = 8;
    localparam int KIND_BITS    = 2;
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;

    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

    localparam logic [HOLD_BITS-1:0]    HOLD_RESET    = HOLD_BITS'(0);
    localparam logic [ELAPSED_BITS-1:0] RAMP_RESET    = ELAPSED_BITS'(100);
    localparam logic [ELAPSED_BITS-1:0] TIMEOUT_RESET = ELAPSED_BITS'(1200);
    localparam logic [DUTY_BITS-1:0]    START_RESET   = DUTY_BITS'(1024);
    localparam logic [DUTY_BITS-1:0]    FLOOR_RESET   = DUTY_BITS'(512);
    localparam logic [STEP_BITS-1:0]    STEP_RESET    = STEP_BITS'(3);

    localparam logic [2:0] REG_HOLD    = 3'd0;
    localparam logic [2:0] REG_RAMP    = 3'd1;
    localparam logic [2:0] REG_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_START   = 3'd3;
    localparam logic [2:0] REG_FLOOR   = 3'd4;
    localparam logic [2:0] REG_STEP    = 3'd5;

    localparam logic [KIND_BITS-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_RAISE   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_LOWER   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_RECOVER = 2'd3;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_RAISE   = 4'b0010,
        MODE_LOWER   = 4'b0100,
        MODE_RECOVER = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        POS_BOTTOM  = 2'd0,
        POS_TOP     = 2'd1,
        POS_MOVING  = 2'd2,
        POS_INVALID = 2'd3
    } pos_t;

    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_RAISED        = 3'd1,
        EV_LOWERED       = 3'd2,
        EV_RAISE_TIMEOUT = 3'd3,
        EV_LOWER_TIMEOUT = 3'd4,
        EV_REFUSED       = 3'd5,
        EV_ABORTED       = 3'd6
    } ev_t;

    typedef struct packed {
        logic [HOLD_BITS-1:0]    hold_ticks;
        logic [ELAPSED_BITS-1:0] ramp_start_ticks;
        logic [ELAPSED_BITS-1:0] timeout_ticks;
        logic [DUTY_BITS-1:0]    start_duty;
        logic [DUTY_BITS-1:0]    floor_duty;
        logic [STEP_BITS-1:0]    duty_step;
    } cfg_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic                 upper_switch;
        logic                 lower_switch;
        logic                 vehicle_present;
    } item_t;

    typedef struct packed {
        mode_t                   mode;
        logic [ELAPSED_BITS-1:0] elapsed_ticks;
        logic [DUTY_BITS-1:0]    raise_level;
        logic [DUTY_BITS-1:0]    lower_level;
        logic                    sensor_off;
    } state_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] raise_duty;
        logic [DUTY_BITS-1:0] lower_duty;
        pos_t                 position;
        ev_t                  event_res;
        logic                 sensor_disable;
    } result_t;

    function automatic logic [DUTY_BITS-1:0] ramp_level(
        input logic [DUTY_BITS-1:0] level,
        input logic [DUTY_BITS-1:0] floor_duty,
        input logic [STEP_BITS-1:0] duty_step
    );
        logic [DUTY_BITS-1:0] step_ext;
        logic [DUTY_BITS-1:0] result;
        step_ext = DUTY_BITS'(duty_step);
        result   = level;
        if (level > floor_duty)
        begin
            result = (level > step_ext) ? level - step_ext : '0;
        end
        return result;
    endfunction

endpackage

// ===== hdl/lsmr_regs.sv =====
// Configuration register bank with its APB-style access port.
`timescale 1ns / 1ps

module lsmr_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsmr_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lsmr_pkg::DATA_BITS-1:0] pwdata,
    output logic [lsmr_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output lsmr_pkg::cfg_t                 cfg
);
    import lsmr_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks       <= HOLD_RESET;
            cfg_reg.ramp_start_ticks <= RAMP_RESET;
            cfg_reg.timeout_ticks    <= TIMEOUT_RESET;
            cfg_reg.start_duty       <= START_RESET;
            cfg_reg.floor_duty       <= FLOOR_RESET;
            cfg_reg.duty_step        <= STEP_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_HOLD:    cfg_reg.hold_ticks       <= pwdata[HOLD_BITS-1:0];
                REG_RAMP:    cfg_reg.ramp_start_ticks <= pwdata[ELAPSED_BITS-1:0];
                REG_TIMEOUT: cfg_reg.timeout_ticks    <= pwdata[ELAPSED_BITS-1:0];
                REG_START:   cfg_reg.start_duty       <= pwdata[DUTY_BITS-1:0];
                REG_FLOOR:   cfg_reg.floor_duty       <= pwdata[DUTY_BITS-1:0];
                REG_STEP:    cfg_reg.duty_step        <= pwdata[STEP_BITS-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_HOLD:    prdata = DATA_BITS'(cfg_reg.hold_ticks);
            REG_RAMP:    prdata = DATA_BITS'(cfg_reg.ramp_start_ticks);
            REG_TIMEOUT: prdata = DATA_BITS'(cfg_reg.timeout_ticks);
            REG_START:   prdata = DATA_BITS'(cfg_reg.start_duty);
            REG_FLOOR:   prdata = DATA_BITS'(cfg_reg.floor_duty);
            REG_STEP:    prdata = DATA_BITS'(cfg_reg.duty_step);
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== hdl/lsmr_step.sv =====
// Next-state and result logic for one request against the drive state.
`timescale 1ns / 1ps

module lsmr_step (
    input  lsmr_pkg::cfg_t    cfg,
    input  lsmr_pkg::item_t   item,
    input  lsmr_pkg::state_t  st,
    output lsmr_pkg::state_t  nxt,
    output lsmr_pkg::result_t res
);
    import lsmr_pkg::*;

    pos_t                    pos;
    ev_t                     ev;
    logic [ELAPSED_BITS-1:0] elapsed_inc;
    logic                    rising;
    logic [DUTY_BITS-1:0]    level;

    function automatic state_t begin_lower(input state_t s, input logic [DUTY_BITS-1:0] duty);
        state_t r;
        r               = s;
        r.raise_level   = '0;
        r.lower_level   = duty;
        r.elapsed_ticks = '0;
        r.sensor_off    = 1'b0;
        r.mode          = MODE_LOWER;
        return r;
    endfunction

    function automatic state_t stop_all(input state_t s);
        state_t r;
        r             = s;
        r.raise_level = '0;
        r.lower_level = '0;
        r.mode        = MODE_IDLE;
        return r;
    endfunction

    always_comb
    begin
        if (!item.upper_switch)
        begin
            pos = item.lower_switch ? POS_MOVING : POS_TOP;
        end
        else
        begin
            pos = item.lower_switch ? POS_BOTTOM : POS_INVALID;
        end
    end

    assign elapsed_inc = (st.elapsed_ticks != ELAPSED_MAX) ? st.elapsed_ticks + 1'b1
                                                           : st.elapsed_ticks;
    assign rising      = (st.mode == MODE_RAISE);
    assign level       = rising ? st.raise_level : st.lower_level;

    always_comb
    begin
        nxt = st;
        ev  = EV_NONE;
        unique case (st.mode) inside
            MODE_IDLE:
            begin
                if (item.kind == KIND_RAISE)
                begin
                    if (item.vehicle_present)
                    begin
                        ev = EV_REFUSED;
                    end
                    else if (pos != POS_TOP)
                    begin
                        nxt.lower_level   = '0;
                        nxt.raise_level   = cfg.start_duty;
                        nxt.elapsed_ticks = '0;
                        nxt.mode          = MODE_RAISE;
                    end
                end
                else if (item.kind == KIND_LOWER)
                begin
                    if (pos != POS_BOTTOM)
                    begin
                        nxt = begin_lower(st, cfg.start_duty);
                    end
                end
                else if (item.kind == KIND_RECOVER)
                begin
                    if (pos == POS_INVALID)
                    begin
                        nxt.raise_level = '0;
                        nxt.lower_level = cfg.start_duty;
                        nxt.mode        = MODE_RECOVER;
                    end
                end
            end
            MODE_RAISE, MODE_LOWER:
            begin
                if (item.kind == KIND_TICK)
                begin
                    nxt.elapsed_ticks = elapsed_inc;
                    if (elapsed_inc > ELAPSED_BITS'(cfg.hold_ticks))
                    begin
                        if (pos != POS_MOVING || level == '0)
                        begin
                            nxt = stop_all(nxt);
                            if (rising && pos == POS_TOP)
                            begin
                                ev             = EV_RAISED;
                                nxt.sensor_off = 1'b1;
                            end
                            else if (!rising && pos == POS_BOTTOM)
                            begin
                                ev = EV_LOWERED;
                            end
                        end
                        else if (rising && item.vehicle_present)
                        begin
                            ev  = EV_ABORTED;
                            nxt = begin_lower(nxt, cfg.start_duty);
                        end
                        else
                        begin
                            if (elapsed_inc >= cfg.ramp_start_ticks)
                            begin
                                if (rising)
                                begin
                                    nxt.raise_level = ramp_level(st.raise_level,
                                                                 cfg.floor_duty, cfg.duty_step);
                                end
                                else
                                begin
                                    nxt.lower_level = ramp_level(st.lower_level,
                                                                 cfg.floor_duty, cfg.duty_step);
                                end
                            end
                            if (elapsed_inc >= cfg.timeout_ticks)
                            begin
                                if (rising)
                                begin
                                    ev  = EV_RAISE_TIMEOUT;
                                    nxt = begin_lower(nxt, cfg.start_duty);
                                end
                                else
                                begin
                                    ev  = EV_LOWER_TIMEOUT;
                                    nxt = stop_all(nxt);
                                end
                            end
                        end
                    end
                end
            end
            MODE_RECOVER:
            begin
                if (item.kind == KIND_TICK)
                begin
                    if (pos != POS_INVALID || st.lower_level == '0)
                    begin
                        nxt = stop_all(st);
                    end
                    else
                    begin
                        nxt.lower_level = ramp_level(st.lower_level, cfg.floor_duty,
                                                     cfg.duty_step);
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res.raise_duty     = nxt.raise_level;
        res.lower_duty     = nxt.lower_level;
        res.position       = pos;
        res.event_res      = ev;
        res.sensor_disable = nxt.sensor_off;
    end

endmodule

// ===== hdl/limit_switch_motor_ramp_controller_top.sv =====
// Top level of the limit switch motor ramp controller: request pipeline and drive state.
//
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid/in_ready    kind, upper_switch, lower_switch, vehicle_present
//  result    out        out_valid/out_ready  raise_duty, lower_duty, position, event_res,
//                                            sensor_disable
//  config    in         psel/penable/pready  paddr, pwdata, prdata
//
// One request is accepted per cycle while the output is not stalled; it waits in the input
// register while the single step pass updates the drive state, and its result is loaded
// into the output register when the request advances. That rate is set by the step pass.
// Reset returns the drive to idle with all levels and the sensor-off flag cleared.
// A stalled result holds the output register; the input register still takes one request
// and the pipeline stops only when both registers are full.
`timescale 1ns / 1ps

module limit_switch_motor_ramp_controller_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lsmr_pkg::KIND_BITS-1:0] kind,
    input  logic                           upper_switch,
    input  logic                           lower_switch,
    input  logic                           vehicle_present,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lsmr_pkg::DUTY_BITS-1:0] raise_duty,
    output logic [lsmr_pkg::DUTY_BITS-1:0] lower_duty,
    output logic [1:0]                     position,
    output logic [2:0]                     event_res,
    output logic                           sensor_disable,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsmr_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lsmr_pkg::DATA_BITS-1:0] pwdata,
    output logic [lsmr_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);
    import lsmr_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;
    logic    advance;

    lsmr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsmr_step u_step (
        .cfg  (cfg),
        .item (item_reg),
        .st   (state_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: MODE_IDLE, elapsed_ticks: '0, raise_level: '0,
                               lower_level: '0, sensor_off: 1'b0};
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{kind: kind, upper_switch: upper_switch, lower_switch: lower_switch,
                          vehicle_present: vehicle_present};
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign raise_duty     = result_reg.raise_duty;
    assign lower_duty     = result_reg.lower_duty;
    assign position       = result_reg.position;
    assign event_res      = result_reg.event_res;
    assign sensor_disable = result_reg.sensor_disable;

`ifndef SYNTHESIS
    a_idle_levels_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode == MODE_IDLE |-> state_reg.raise_level == '0 && state_reg.lower_level == '0)
        else $error("idle drive holds a nonzero level");

    a_one_channel: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode != MODE_RAISE |-> state_reg.raise_level == '0)
        else $error("raising channel driven outside a raise");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("drive state changed without a request being processed");

    a_request_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("pending request lost while the output stalled");

    a_raised_disables: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.event_res == EV_RAISED |-> result_reg.sensor_disable)
        else $error("completed raise did not disable the ground sensor");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the limit switch motor ramp controller.
`timescale 1ns / 1ps

module tb_top;

    import lsmr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 in_valid        = 1'b0;
    logic                 in_ready;
    logic [KIND_BITS-1:0] kind            = '0;
    logic                 upper_switch    = 1'b0;
    logic                 lower_switch    = 1'b0;
    logic                 vehicle_present = 1'b0;
    logic                 out_valid;
    logic                 out_ready       = 1'b0;
    logic [DUTY_BITS-1:0] raise_duty;
    logic [DUTY_BITS-1:0] lower_duty;
    logic [1:0]           position;
    logic [2:0]           event_res;
    logic                 sensor_disable;
    logic                 psel            = 1'b0;
    logic                 penable         = 1'b0;
    logic                 pwrite          = 1'b0;
    logic [ADDR_BITS-1:0] paddr           = '0;
    logic [DATA_BITS-1:0] pwdata          = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // Register copies held by the predictor.
    logic [HOLD_BITS-1:0]    set_hold    = HOLD_RESET;
    logic [ELAPSED_BITS-1:0] set_ramp    = RAMP_RESET;
    logic [ELAPSED_BITS-1:0] set_timeout = TIMEOUT_RESET;
    logic [DUTY_BITS-1:0]    set_start   = START_RESET;
    logic [DUTY_BITS-1:0]    set_floor   = FLOOR_RESET;
    logic [STEP_BITS-1:0]    set_step    = STEP_RESET;

    // Drive state held by the predictor.
    mode_t                   drv_mode       = MODE_IDLE;
    logic [ELAPSED_BITS-1:0] drv_elapsed    = '0;
    logic [DUTY_BITS-1:0]    drv_raise      = '0;
    logic [DUTY_BITS-1:0]    drv_lower      = '0;
    logic                    drv_sensor_off = 1'b0;

    result_t pending_reports[$];
    int      requests_sent = 0;
    int      burst_left    = 0;
    int      fail_count    = 0;
    int      cycle_count   = 0;

    limit_switch_motor_ramp_controller_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .upper_switch    (upper_switch),
        .lower_switch    (lower_switch),
        .vehicle_present (vehicle_present),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .raise_duty      (raise_duty),
        .lower_duty      (lower_duty),
        .position        (position),
        .event_res       (event_res),
        .sensor_disable  (sensor_disable),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #6 clk = ~clk;

    function automatic logic [DUTY_BITS-1:0] ramp_down(input logic [DUTY_BITS-1:0] level);
        logic [DUTY_BITS-1:0] stride;
        stride = {3'b000, set_step};
        if (level > set_floor)
        begin
            level = (level > stride) ? level - stride : '0;
        end
        return level;
    endfunction

    function automatic void halt_drive();
        drv_raise = '0;
        drv_lower = '0;
        drv_mode  = MODE_IDLE;
    endfunction

    function automatic void start_lowering();
        drv_raise      = '0;
        drv_lower      = set_start;
        drv_elapsed    = '0;
        drv_sensor_off = 1'b0;
        drv_mode       = MODE_LOWER;
    endfunction

    function automatic result_t advance_drive(input logic [KIND_BITS-1:0] k, input logic up,
                                              input logic lo, input logic veh);
        pos_t                 p;
        ev_t                  ev;
        logic                 rising;
        logic [DUTY_BITS-1:0] lvl;
        result_t              r;
        ev = EV_NONE;
        p  = up ? (lo ? POS_BOTTOM : POS_INVALID) : (lo ? POS_MOVING : POS_TOP);
        if (k != KIND_TICK)
        begin
            if (drv_mode == MODE_IDLE)
            begin
                if (k == KIND_RAISE)
                begin
                    if (veh)
                    begin
                        ev = EV_REFUSED;
                    end
                    else if (p != POS_TOP)
                    begin
                        drv_lower   = '0;
                        drv_raise   = set_start;
                        drv_elapsed = '0;
                        drv_mode    = MODE_RAISE;
                    end
                end
                else if (k == KIND_LOWER)
                begin
                    if (p != POS_BOTTOM)
                    begin
                        start_lowering();
                    end
                end
                else if (p == POS_INVALID)
                begin
                    drv_raise = '0;
                    drv_lower = set_start;
                    drv_mode  = MODE_RECOVER;
                end
            end
        end
        else if (drv_mode == MODE_RAISE || drv_mode == MODE_LOWER)
        begin
            if (drv_elapsed != ELAPSED_MAX)
            begin
                drv_elapsed = drv_elapsed + 1'b1;
            end
            if (drv_elapsed > {2'b00, set_hold})
            begin
                rising = (drv_mode == MODE_RAISE);
                lvl    = rising ? drv_raise : drv_lower;
                if (p != POS_MOVING || lvl == '0)
                begin
                    halt_drive();
                    if (rising && p == POS_TOP)
                    begin
                        ev             = EV_RAISED;
                        drv_sensor_off = 1'b1;
                    end
                    else if (!rising && p == POS_BOTTOM)
                    begin
                        ev = EV_LOWERED;
                    end
                end
                else if (rising && veh)
                begin
                    ev = EV_ABORTED;
                    start_lowering();
                end
                else
                begin
                    if (drv_elapsed >= set_ramp)
                    begin
                        if (rising)
                        begin
                            drv_raise = ramp_down(drv_raise);
                        end
                        else
                        begin
                            drv_lower = ramp_down(drv_lower);
                        end
                    end
                    if (drv_elapsed >= set_timeout)
                    begin
                        if (rising)
                        begin
                            ev = EV_RAISE_TIMEOUT;
                            start_lowering();
                        end
                        else
                        begin
                            ev = EV_LOWER_TIMEOUT;
                            halt_drive();
                        end
                    end
                end
            end
        end
        else if (drv_mode == MODE_RECOVER)
        begin
            if (p != POS_INVALID || drv_lower == '0)
            begin
                halt_drive();
            end
            else
            begin
                drv_lower = ramp_down(drv_lower);
            end
        end
        r.raise_duty     = drv_raise;
        r.lower_duty     = drv_lower;
        r.position       = p;
        r.event_res      = ev;
        r.sensor_disable = drv_sensor_off;
        return r;
    endfunction

    function automatic void check_field(input string label, input logic [10:0] want,
                                        input logic [10:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, label, want, got);
        end
    endfunction

    task automatic send_request(input logic [KIND_BITS-1:0] k, input logic up, input logic lo,
                                input logic veh);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid        <= 1'b1;
        kind            <= k;
        upper_switch    <= up;
        lower_switch    <= lo;
        vehicle_present <= veh;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_reports.push_back(advance_drive(k, up, lo, veh));
        requests_sent++;
    endtask

    task automatic wait_for_all_reports();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HOLD:    set_hold    = HOLD_BITS'(value);
            REG_RAMP:    set_ramp    = ELAPSED_BITS'(value);
            REG_TIMEOUT: set_timeout = ELAPSED_BITS'(value);
            REG_START:   set_start   = DUTY_BITS'(value);
            REG_FLOOR:   set_floor   = DUTY_BITS'(value);
            REG_STEP:    set_step    = STEP_BITS'(value);
            default:     ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input int unsigned hold, input int unsigned ramp_at,
                                  input int unsigned timeout, input int unsigned start,
                                  input int unsigned floor_level, input int unsigned step);
        write_reg(REG_HOLD, hold);
        write_reg(REG_RAMP, ramp_at);
        write_reg(REG_TIMEOUT, timeout);
        write_reg(REG_START, start);
        write_reg(REG_FLOOR, floor_level);
        write_reg(REG_STEP, step);
    endtask

    // Ticks at the top pair end any drive once the blind hold has passed.
    task automatic settle_to_rest();
        while (drv_mode != MODE_IDLE)
        begin
            send_request(KIND_TICK, 1'b0, 1'b0, 1'($urandom));
        end
    endtask

    task automatic send_drive_run(input logic [KIND_BITS-1:0] cmd);
        int         len;
        int         i;
        logic [1:0] pair;
        logic [1:0] goal;
        logic       veh;
        if (drv_mode != MODE_IDLE && $urandom_range(0, 3) != 0)
        begin
            settle_to_rest();
        end
        veh = 1'b0;
        case (cmd)
            KIND_RAISE:
            begin
                pair = $urandom_range(0, 1) ? 2'b11 : 2'b01;
                goal = 2'b00;
                veh  = ($urandom_range(0, 7) == 0);
            end
            KIND_LOWER:
            begin
                pair = $urandom_range(0, 1) ? 2'b00 : 2'b01;
                goal = 2'b11;
                veh  = 1'($urandom);
            end
            default:
            begin
                pair = 2'b10;
                goal = $urandom_range(0, 1) ? 2'b00 : 2'b11;
            end
        endcase
        if ($urandom_range(0, 4) == 0)
        begin
            pair = 2'($urandom);
        end
        send_request(cmd, pair[1], pair[0], veh);
        if (cmd == KIND_RECOVER)
        begin
            len = $urandom_range(0, 12);
        end
        else
        begin
            len = set_hold + $urandom_range(0, (set_timeout < 30) ? set_timeout + 2 : 30);
        end
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_request(KIND_BITS'($urandom_range(1, 3)), 1'($urandom), 1'($urandom),
                             1'($urandom));
            end
            else if (cmd == KIND_RECOVER)
            begin
                send_request(KIND_TICK, 1'b1, 1'b0, 1'($urandom));
            end
            else if (cmd == KIND_RAISE)
            begin
                send_request(KIND_TICK, 1'b0, 1'b1, ($urandom_range(0, 15) == 0));
            end
            else
            begin
                send_request(KIND_TICK, 1'b0, 1'b1, 1'($urandom));
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            goal = 2'($urandom);
        end
        send_request(KIND_TICK, goal[1], goal[0], ($urandom_range(0, 7) == 0));
    endtask

    task automatic test_directed_cases();
        send_request(KIND_TICK, 1'b0, 1'b0, 1'b0);
        send_request(KIND_TICK, 1'b1, 1'b1, 1'b1);
        send_request(KIND_RAISE, 1'b1, 1'b1, 1'b1);
        send_request(KIND_RAISE, 1'b0, 1'b0, 1'b0);
        send_request(KIND_LOWER, 1'b1, 1'b1, 1'b0);
        send_request(KIND_RECOVER, 1'b0, 1'b1, 1'b0);
        send_request(KIND_RAISE, 1'b1, 1'b1, 1'b0);
        send_request(KIND_LOWER, 1'b0, 1'b1, 1'b0);
        send_request(KIND_RECOVER, 1'b1, 1'b0, 1'b0);
        send_request(KIND_TICK, 1'b0, 1'b1, 1'b0);
        send_request(KIND_TICK, 1'b0, 1'b1, 1'b0);
        send_request(KIND_TICK, 1'b0, 1'b1, 1'b1);
        send_request(KIND_TICK, 1'b0, 1'b1, 1'b0);
        send_request(KIND_TICK, 1'b1, 1'b1, 1'b0);
        send_request(KIND_RAISE, 1'b0, 1'b1, 1'b0);
        send_request(KIND_TICK, 1'b0, 1'b1, 1'b0);
        send_request(KIND_TICK, 1'b0, 1'b0, 1'b0);
        send_request(KIND_LOWER, 1'b0, 1'b0, 1'b0);
        send_request(KIND_TICK, 1'b1, 1'b0, 1'b0);
        send_request(KIND_RECOVER, 1'b1, 1'b0, 1'b1);
        send_request(KIND_TICK, 1'b1, 1'b0, 1'b0);
        send_request(KIND_TICK, 1'b1, 1'b0, 1'b0);
        send_request(KIND_TICK, 1'b0, 1'b1, 1'b0);
        send_request(KIND_RAISE, 1'b1, 1'b1, 1'b0);
        send_request(KIND_TICK, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_timeouts_and_ramp();
        wait_for_all_reports();
        // A short blind hold, then a steep ramp that runs the duty out to nothing.
        apply_settings(2, 3, 8, 40, 0, 15);
        send_request(KIND_RAISE, 1'b1, 1'b1, 1'b0);
        repeat (7) send_request(KIND_TICK, 1'b0, 1'b1, 1'b0);
        wait_for_all_reports();
        apply_settings(0, 2, 5, 1024, 512, 255);
        send_request(KIND_RAISE, 1'b1, 1'b1, 1'b0);
        repeat (10) send_request(KIND_TICK, 1'b0, 1'b1, 1'b0);
        wait_for_all_reports();
        apply_settings(0, 100, 1200, 0, 512, 3);
        send_request(KIND_RAISE, 1'b1, 1'b1, 1'b0);
        send_request(KIND_TICK, 1'b0, 1'b1, 1'b0);
        send_request(KIND_RECOVER, 1'b1, 1'b0, 1'b0);
        send_request(KIND_TICK, 1'b1, 1'b0, 1'b0);
        send_request(KIND_LOWER, 1'b0, 1'b0, 1'b0);
        send_request(KIND_TICK, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_register_extremes();
        int i;
        wait_for_all_reports();
        apply_settings(0, 0, 0, 1024, 1024, 0);
        send_request(KIND_RAISE, 1'b0, 1'b1, 1'b0);
        send_request(KIND_TICK, 1'b0, 1'b1, 1'b0);
        send_request(KIND_TICK, 1'b0, 1'b1, 1'b0);
        send_request(KIND_RECOVER, 1'b1, 1'b0, 1'b0);
        send_request(KIND_TICK, 1'b1, 1'b0, 1'b0);
        send_request(KIND_TICK, 1'b0, 1'b0, 1'b0);
        wait_for_all_reports();
        apply_settings(1023, 4095, 4095, 1024, 0, 255);
        send_request(KIND_RAISE, 1'b1, 1'b1, 1'b1);
        send_request(KIND_RAISE, 1'b0, 1'b0, 1'b0);
        send_request(KIND_LOWER, 1'b1, 1'b1, 1'b0);
        send_request(KIND_RECOVER, 1'b0, 1'b0, 1'b1);
        send_request(KIND_TICK, 1'b1, 1'b0, 1'b1);
        wait_for_all_reports();
        // A long blind hold ignores whatever the switches report.
        apply_settings(40, 4095, 4095, 1024, 0, 255);
        send_request(KIND_RAISE, 1'b1, 1'b1, 1'b0);
        for (i = 0; i < 40; i++)
        begin
            send_request(KIND_TICK, 1'($urandom), 1'($urandom), 1'($urandom));
        end
        settle_to_rest();
    endtask

    task automatic test_random_traffic();
        int phase;
        int target;
        int choice;
        bit paused;
        paused = 1'b0;
        for (phase = 0; phase < 5; phase++)
        begin
            wait_for_all_reports();
            apply_settings($urandom_range(0, 6),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, 24),
                           ($urandom_range(0, 4) == 0) ? 4095 : $urandom_range(0, 40),
                           ($urandom_range(0, 3) == 0) ? 1024 : $urandom_range(0, 1024),
                           $urandom_range(0, 1024),
                           $urandom_range(0, 255));
            target = requests_sent + 100;
            while (requests_sent < target)
            begin
                if (phase == 2 && !paused && requests_sent >= target - 50)
                begin
                    wait_for_all_reports();
                    paused = 1'b1;
                end
                choice = $urandom_range(0, 9);
                if (choice < 4)
                begin
                    send_drive_run(KIND_RAISE);
                end
                else if (choice < 7)
                begin
                    send_drive_run(KIND_LOWER);
                end
                else if (choice < 8)
                begin
                    send_drive_run(KIND_RECOVER);
                end
                else
                begin
                    send_request(KIND_BITS'($urandom), 1'($urandom), 1'($urandom),
                                 1'($urandom));
                end
            end
            settle_to_rest();
        end
    endtask

    always @(posedge clk)
    begin : check_reports
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                fail_count++;
                $display("%0t result arrived with no request outstanding", $time);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("raise_duty", want.raise_duty, raise_duty);
                check_field("lower_duty", want.lower_duty, lower_duty);
                check_field("position", 11'(want.position), 11'(position));
                check_field("event_res", 11'(want.event_res), 11'(event_res));
                check_field("sensor_disable", 11'(want.sensor_disable), 11'(sensor_disable));
            end
        end
    end

    // The receiver alternates between free flow, light and heavy stalls, and a fixed rhythm.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        case ((cycle_count / 150) % 4)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((cycle_count % 7) > 2);
        endcase
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_timeouts_and_ramp();
        test_register_extremes();
        test_random_traffic();
        wait_for_all_reports();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== limit_switch_motor_ramp_controller_top.f =====
hdl/lsmr_pkg.sv
hdl/lsmr_regs.sv
hdl/lsmr_step.sv
hdl/limit_switch_motor_ramp_controller_top.sv
dv/tb_top.sv
